>>> hw/rtl/flvthp_pkg.sv
// Shared types, record codes and stream constants of the FLV tag header parser.
package flvthp_pkg;

    // Name length at which the matcher stops and clears every candidate scheme.
    localparam logic [4:0] MAX_NAME_BYTES = 5'd16;

    localparam logic [1:0] REC_FILE  = 2'd0;
    localparam logic [1:0] REC_TAG   = 2'd1;
    localparam logic [1:0] REC_ERROR = 2'd2;

    localparam logic [1:0] SCHEME_NONE = 2'd0;
    localparam logic [1:0] SCHEME_ENC  = 2'd1;
    localparam logic [1:0] SCHEME_SE   = 2'd2;
    localparam logic [1:0] MATCH_BOTH  = 2'b11;

    localparam logic [4:0] ENC_NAME_LEN = 5'd10;
    localparam logic [4:0] SE_NAME_LEN  = 5'd2;
    localparam logic [4:0] IV_BYTES     = 5'd16;

    localparam logic [4:0] TYPE_AUDIO  = 5'd8;
    localparam logic [4:0] TYPE_VIDEO  = 5'd9;
    localparam logic [3:0] FORMAT_AAC  = 4'hA;
    localparam logic [3:0] CODEC_AVC   = 4'h7;

    localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;

    typedef struct packed {
        logic [1:0] match;
        logic [4:0] length;
    } name_state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  tag_code;
        logic        filter;
        logic [23:0] tag_size;
        logic [31:0] timestamp;
        logic [23:0] stream_num;
        logic [7:0]  media_flags;
        logic [7:0]  packet_type;
        logic [23:0] comp_time;
        logic [1:0]  av_present;
        logic [1:0]  filter_scheme;
        logic        au_encrypted;
    } record_t;

    // File signature "FLV".
    function automatic logic [7:0] sig_byte(input logic [1:0] idx);
        logic [7:0] c;
        begin
            case (idx)
                2'd0:    c = 8'h46;
                2'd1:    c = 8'h4C;
                default: c = 8'h56;
            endcase
            return c;
        end
    endfunction

    // Filter name "Encryption".
    function automatic logic [7:0] enc_char(input logic [3:0] idx);
        logic [7:0] c;
        begin
            case (idx)
                4'd0:    c = 8'h45;
                4'd1:    c = 8'h6E;
                4'd2:    c = 8'h63;
                4'd3:    c = 8'h72;
                4'd4:    c = 8'h79;
                4'd5:    c = 8'h70;
                4'd6:    c = 8'h74;
                4'd7:    c = 8'h69;
                4'd8:    c = 8'h6F;
                4'd9:    c = 8'h6E;
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

    // Filter name "SE".
    function automatic logic [7:0] se_char(input logic idx);
        return idx ? 8'h45 : 8'h53;
    endfunction

endpackage

>>> hw/rtl/flvthp_name_match.sv
// Filter name matcher: narrows the candidate schemes by one name byte.
module flvthp_name_match
(
    input  flvthp_pkg::name_state_t cur,
    input  logic [7:0]              data_byte,
    output flvthp_pkg::name_state_t nxt
);

    always_comb
    begin
        nxt = cur;
        if (data_byte == 8'h00)
        begin
            // The terminator settles the scheme; only full-length matches count.
            if (cur.match[0] && cur.length == flvthp_pkg::ENC_NAME_LEN)
                nxt.match = flvthp_pkg::SCHEME_ENC;
            else if (cur.match[1] && cur.length == flvthp_pkg::SE_NAME_LEN)
                nxt.match = flvthp_pkg::SCHEME_SE;
            else
                nxt.match = flvthp_pkg::SCHEME_NONE;
        end
        else if (cur.length >= flvthp_pkg::MAX_NAME_BYTES)
        begin
            nxt.match = 2'b00;
        end
        else
        begin
            if (cur.length >= flvthp_pkg::ENC_NAME_LEN
                || data_byte != flvthp_pkg::enc_char(cur.length[3:0]))
                nxt.match[0] = 1'b0;
            if (cur.length >= flvthp_pkg::SE_NAME_LEN
                || data_byte != flvthp_pkg::se_char(cur.length[0]))
                nxt.match[1] = 1'b0;
            nxt.length = cur.length + 5'd1;
        end
    end

endmodule

>>> hw/rtl/flv_tag_header_parser_core.sv
// FLV tag header parser: one stream byte per beat in, header records out.
//
// The input channel (in_valid, in_ready, data_byte) carries an FLV byte
// stream, one byte per beat. The output channel (out_valid, out_ready and
// the record fields) carries at most one record per input byte: a file
// header record after the ninth stream byte, one tag record per tag once
// its header, media subheader and any encryption filter header are parsed,
// or an error record when the "FLV" signature is wrong.
// An accepted byte is held in an input register and is then parsed
// by combinational logic into the state registers and the record register.
// A record is therefore valid once its last byte has passed both registers.
// The block takes one byte every cycle as long as the record register is
// empty or being emptied; a stalled receiver blocks the parse stage, and
// the input register then absorbs one more beat before in_ready drops.
// Reset puts the parser at the first signature byte with all held fields
// cleared and both channels empty. After an error record every later byte
// is accepted and dropped until the next reset.
// Payload bytes after the subheaders are skipped by a down counter loaded
// from data size less subheader bytes; subheaders that overrun it give no skip.
module flv_tag_header_parser_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  record_kind,
    output logic [4:0]  tag_code,
    output logic        filter,
    output logic [23:0] tag_size,
    output logic [31:0] timestamp,
    output logic [23:0] stream_num,
    output logic [7:0]  media_flags,
    output logic [7:0]  packet_type,
    output logic [23:0] comp_time,
    output logic [1:0]  av_present,
    output logic [1:0]  filter_scheme,
    output logic        au_encrypted
);

    // Parser phases.
    localparam logic [3:0] PH_FILE      = 4'd0;
    localparam logic [3:0] PH_PREV      = 4'd1;
    localparam logic [3:0] PH_TAG       = 4'd2;
    localparam logic [3:0] PH_AUD_FLAGS = 4'd3;
    localparam logic [3:0] PH_AUD_PKT   = 4'd4;
    localparam logic [3:0] PH_VID_FLAGS = 4'd5;
    localparam logic [3:0] PH_VID_PKT   = 4'd6;
    localparam logic [3:0] PH_VID_CT    = 4'd7;
    localparam logic [3:0] PH_F_NUM     = 4'd8;
    localparam logic [3:0] PH_F_NAME    = 4'd9;
    localparam logic [3:0] PH_F_LEN     = 4'd10;
    localparam logic [3:0] PH_F_IV      = 4'd11;
    localparam logic [3:0] PH_SE_FLAGS  = 4'd12;
    localparam logic [3:0] PH_SKIP      = 4'd13;

    // Input register.
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;

    // Parser state.
    logic [3:0]  phase_reg, phase_next;
    logic [4:0]  byte_idx_reg, byte_idx_next;
    logic [23:0] consumed_reg, consumed_next;
    logic [23:0] skip_reg, skip_next;
    logic [4:0]  held_type_reg, held_type_next;
    logic        held_filter_reg, held_filter_next;
    logic [23:0] held_size_reg, held_size_next;
    logic [31:0] held_time_reg, held_time_next;
    logic [23:0] held_stream_reg, held_stream_next;
    logic [7:0]  held_media_reg, held_media_next;
    logic [7:0]  held_packet_reg, held_packet_next;
    logic [23:0] held_comp_reg, held_comp_next;
    logic        held_au_reg, held_au_next;
    logic        stopped_reg, stopped_next;
    flvthp_pkg::name_state_t name_reg, name_next, name_step;

    // Record register.
    logic                out_valid_reg, out_valid_next;
    flvthp_pkg::record_t rec_reg, rec_next;

    logic        advance;
    logic        emit;
    logic        av_done;
    logic        do_finish;
    logic [7:0]  b;

    // The parse stage moves whenever the record register can take a record.
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;
    assign b        = s1_byte_reg;

    flvthp_name_match u_name_match
    (
        .cur       (name_reg),
        .data_byte (s1_byte_reg),
        .nxt       (name_step)
    );

    always_comb
    begin
        phase_next       = phase_reg;
        byte_idx_next    = byte_idx_reg;
        consumed_next    = consumed_reg;
        skip_next        = skip_reg;
        held_type_next   = held_type_reg;
        held_filter_next = held_filter_reg;
        held_size_next   = held_size_reg;
        held_time_next   = held_time_reg;
        held_stream_next = held_stream_reg;
        held_media_next  = held_media_reg;
        held_packet_next = held_packet_reg;
        held_comp_next   = held_comp_reg;
        held_au_next     = held_au_reg;
        stopped_next     = stopped_reg;
        name_next        = name_reg;
        rec_next         = '0;
        emit             = 1'b0;
        av_done          = 1'b0;
        do_finish        = 1'b0;

        if (s1_valid_reg && advance && !stopped_reg)
        begin
            // Subheader bytes are counted against the tag's data size.
            if (phase_reg >= PH_AUD_FLAGS && phase_reg <= PH_SE_FLAGS
                && consumed_reg != flvthp_pkg::COUNT_MAX)
                consumed_next = consumed_reg + 24'd1;

            unique case (phase_reg)
                PH_FILE:
                begin
                    if (byte_idx_reg < 5'd3
                        && b != flvthp_pkg::sig_byte(byte_idx_reg[1:0]))
                    begin
                        rec_next.kind = flvthp_pkg::REC_ERROR;
                        emit          = 1'b1;
                        stopped_next  = 1'b1;
                    end
                    else
                    begin
                        if (byte_idx_reg == 5'd3)
                            held_media_next = b;
                        if (byte_idx_reg == 5'd4)
                            held_packet_next = {6'd0, b[2], b[0]};
                        byte_idx_next = byte_idx_reg + 5'd1;
                        if (byte_idx_reg == 5'd8)
                        begin
                            // The data offset bytes are dropped.
                            rec_next.kind        = flvthp_pkg::REC_FILE;
                            rec_next.media_flags = held_media_next;
                            rec_next.av_present  = held_packet_next[1:0];
                            emit                 = 1'b1;
                            held_media_next      = 8'd0;
                            held_packet_next     = 8'd0;
                            byte_idx_next        = 5'd0;
                            phase_next           = PH_PREV;
                        end
                    end
                end
                PH_PREV:
                begin
                    byte_idx_next = byte_idx_reg + 5'd1;
                    if (byte_idx_reg == 5'd3)
                    begin
                        byte_idx_next = 5'd0;
                        phase_next    = PH_TAG;
                    end
                end
                PH_TAG:
                begin
                    if (byte_idx_reg == 5'd0)
                    begin
                        held_filter_next = b[5];
                        held_type_next   = b[4:0];
                        held_size_next   = 24'd0;
                        held_time_next   = 32'd0;
                        held_stream_next = 24'd0;
                        held_media_next  = 8'd0;
                        held_packet_next = 8'd0;
                        held_comp_next   = 24'd0;
                        held_au_next     = 1'b0;
                        name_next.match  = flvthp_pkg::MATCH_BOTH;
                        name_next.length = 5'd0;
                    end
                    else if (byte_idx_reg <= 5'd3)
                        held_size_next = {held_size_reg[15:0], b};
                    else if (byte_idx_reg <= 5'd6)
                        held_time_next = {8'd0, held_time_reg[15:0], b};
                    else if (byte_idx_reg == 5'd7)
                        held_time_next = {b, held_time_reg[23:0]};
                    else
                        held_stream_next = {held_stream_reg[15:0], b};
                    byte_idx_next = byte_idx_reg + 5'd1;
                    if (byte_idx_reg == 5'd10)
                    begin
                        consumed_next = 24'd0;
                        byte_idx_next = 5'd0;
                        if (held_type_reg == flvthp_pkg::TYPE_AUDIO)
                            phase_next = PH_AUD_FLAGS;
                        else if (held_type_reg == flvthp_pkg::TYPE_VIDEO)
                            phase_next = PH_VID_FLAGS;
                        else
                            av_done = 1'b1;
                    end
                end
                PH_AUD_FLAGS:
                begin
                    held_media_next = b;
                    if (b[7:4] == flvthp_pkg::FORMAT_AAC)
                        phase_next = PH_AUD_PKT;
                    else
                        av_done = 1'b1;
                end
                PH_AUD_PKT:
                begin
                    held_packet_next = b;
                    av_done          = 1'b1;
                end
                PH_VID_FLAGS:
                begin
                    held_media_next = b;
                    if (b[3:0] == flvthp_pkg::CODEC_AVC)
                        phase_next = PH_VID_PKT;
                    else
                        av_done = 1'b1;
                end
                PH_VID_PKT:
                begin
                    held_packet_next = b;
                    byte_idx_next    = 5'd0;
                    phase_next       = PH_VID_CT;
                end
                PH_VID_CT:
                begin
                    held_comp_next = {held_comp_reg[15:0], b};
                    byte_idx_next  = byte_idx_reg + 5'd1;
                    if (byte_idx_reg == 5'd2)
                    begin
                        byte_idx_next = 5'd0;
                        av_done       = 1'b1;
                    end
                end
                PH_F_NUM:
                begin
                    name_next.match  = flvthp_pkg::MATCH_BOTH;
                    name_next.length = 5'd0;
                    phase_next       = PH_F_NAME;
                end
                PH_F_NAME:
                begin
                    name_next = name_step;
                    if (b == 8'h00)
                    begin
                        byte_idx_next = 5'd0;
                        phase_next    = PH_F_LEN;
                    end
                end
                PH_F_LEN:
                begin
                    byte_idx_next = byte_idx_reg + 5'd1;
                    if (byte_idx_reg == 5'd2)
                    begin
                        byte_idx_next = 5'd0;
                        if (name_reg.match == flvthp_pkg::SCHEME_ENC)
                            phase_next = PH_F_IV;
                        else if (name_reg.match == flvthp_pkg::SCHEME_SE)
                            phase_next = PH_SE_FLAGS;
                        else
                            do_finish = 1'b1;
                    end
                end
                PH_SE_FLAGS:
                begin
                    held_au_next  = b[7];
                    byte_idx_next = 5'd0;
                    if (b[7])
                        phase_next = PH_F_IV;
                    else
                        do_finish = 1'b1;
                end
                PH_F_IV:
                begin
                    byte_idx_next = byte_idx_reg + 5'd1;
                    if (byte_idx_next >= flvthp_pkg::IV_BYTES)
                        do_finish = 1'b1;
                end
                PH_SKIP:
                begin
                    if (skip_reg != 24'd0)
                        skip_next = skip_reg - 24'd1;
                    if (skip_reg <= 24'd1)
                    begin
                        byte_idx_next = 5'd0;
                        phase_next    = PH_PREV;
                    end
                end
                default:
                begin
                    byte_idx_next = 5'd0;
                    phase_next    = PH_PREV;
                end
            endcase

            // Media subheader done: go on to the filter header if there is one.
            if (av_done)
            begin
                if (held_filter_next)
                    phase_next = PH_F_NUM;
                else
                    do_finish = 1'b1;
            end

            // Tag complete: emit its record and load the payload skip count.
            if (do_finish)
            begin
                rec_next.kind          = flvthp_pkg::REC_TAG;
                rec_next.tag_code      = held_type_next;
                rec_next.filter        = held_filter_next;
                rec_next.tag_size      = held_size_next;
                rec_next.timestamp     = held_time_next;
                rec_next.stream_num    = held_stream_next;
                rec_next.media_flags   = held_media_next;
                rec_next.packet_type   = held_packet_next;
                rec_next.comp_time     = held_comp_next;
                rec_next.filter_scheme = held_filter_next ? name_next.match
                                                          : flvthp_pkg::SCHEME_NONE;
                rec_next.au_encrypted  = held_au_next;
                emit                   = 1'b1;
                skip_next = (held_size_next > consumed_next)
                          ? held_size_next - consumed_next : 24'd0;
                byte_idx_next = 5'd0;
                phase_next = (skip_next == 24'd0) ? PH_PREV : PH_SKIP;
            end
        end
    end

    always_comb
    begin
        if (in_valid && in_ready)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            phase_reg       <= PH_FILE;
            byte_idx_reg    <= 5'd0;
            consumed_reg    <= 24'd0;
            skip_reg        <= 24'd0;
            held_type_reg   <= 5'd0;
            held_filter_reg <= 1'b0;
            held_size_reg   <= 24'd0;
            held_time_reg   <= 32'd0;
            held_stream_reg <= 24'd0;
            held_media_reg  <= 8'd0;
            held_packet_reg <= 8'd0;
            held_comp_reg   <= 24'd0;
            held_au_reg     <= 1'b0;
            stopped_reg     <= 1'b0;
            name_reg.match  <= flvthp_pkg::MATCH_BOTH;
            name_reg.length <= 5'd0;
        end
        else
        begin
            s1_valid_reg    <= s1_valid_next;
            out_valid_reg   <= out_valid_next;
            phase_reg       <= phase_next;
            byte_idx_reg    <= byte_idx_next;
            consumed_reg    <= consumed_next;
            skip_reg        <= skip_next;
            held_type_reg   <= held_type_next;
            held_filter_reg <= held_filter_next;
            held_size_reg   <= held_size_next;
            held_time_reg   <= held_time_next;
            held_stream_reg <= held_stream_next;
            held_media_reg  <= held_media_next;
            held_packet_reg <= held_packet_next;
            held_comp_reg   <= held_comp_next;
            held_au_reg     <= held_au_next;
            stopped_reg     <= stopped_next;
            name_reg        <= name_next;
        end
    end

    // Payload registers: loaded on a beat or a new record only.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_byte_reg <= data_byte;
        if (emit)
            rec_reg <= rec_next;
    end

    assign out_valid     = out_valid_reg;
    assign record_kind   = rec_reg.kind;
    assign tag_code      = rec_reg.tag_code;
    assign filter        = rec_reg.filter;
    assign tag_size      = rec_reg.tag_size;
    assign timestamp     = rec_reg.timestamp;
    assign stream_num    = rec_reg.stream_num;
    assign media_flags   = rec_reg.media_flags;
    assign packet_type   = rec_reg.packet_type;
    assign comp_time     = rec_reg.comp_time;
    assign av_present    = rec_reg.av_present;
    assign filter_scheme = rec_reg.filter_scheme;
    assign au_encrypted  = rec_reg.au_encrypted;

endmodule

>>> hw/rtl/flvthp_checker.sv
// Port-level checks of the FLV tag header parser and their bind to the top level.
module flvthp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [7:0]  data_byte,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  record_kind,
    input logic [4:0]  tag_code,
    input logic        filter,
    input logic [23:0] tag_size,
    input logic [31:0] timestamp,
    input logic [23:0] stream_num,
    input logic [7:0]  media_flags,
    input logic [7:0]  packet_type,
    input logic [23:0] comp_time,
    input logic [1:0]  av_present,
    input logic [1:0]  filter_scheme,
    input logic        au_encrypted
);

    logic seen_any_reg;
    logic seen_error_reg;
    logic out_beat;

    assign out_beat = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_any_reg   <= 1'b0;
            seen_error_reg <= 1'b0;
        end
        else
        begin
            if (out_beat)
                seen_any_reg <= 1'b1;
            if (out_beat && record_kind == flvthp_pkg::REC_ERROR)
                seen_error_reg <= 1'b1;
        end
    end

    // A stalled record holds still.
    a_record_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(record_kind)
            && $stable(tag_size) && $stable(timestamp) && $stable(stream_num))
        else $error("record changed while stalled");

    // Nothing follows an error record until reset.
    a_silent_after_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !seen_error_reg)
        else $error("record after signature error");

    // The first record is the file header or the signature error.
    a_first_record: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !seen_any_reg |-> record_kind == flvthp_pkg::REC_FILE
            || record_kind == flvthp_pkg::REC_ERROR)
        else $error("first record is a tag record");

    // Error records carry nothing but their kind.
    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && record_kind == flvthp_pkg::REC_ERROR |-> tag_code == 5'd0
            && tag_size == 24'd0 && media_flags == 8'd0 && av_present == 2'd0
            && filter_scheme == 2'd0 && !filter && !au_encrypted)
        else $error("error record has nonzero fields");

    // Tag and error records never show presence bits; error records never show tag fields.
    a_kind_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && record_kind != flvthp_pkg::REC_FILE |-> av_present == 2'd0
            && (record_kind == flvthp_pkg::REC_TAG || (packet_type == 8'd0
            && comp_time == 24'd0 && stream_num == 24'd0 && timestamp == 32'd0)))
        else $error("record fields do not fit its kind");

endmodule

bind flv_tag_header_parser_core flvthp_checker u_flvthp_checker (.*);
